>>> rtl/lsca_pkg.sv
// Shared types, constants and the arctangent table for the lidar sector centering block.
`default_nettype none
package lsca_pkg;

    localparam int MAX_SAMPLES_DEF  = 4096;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int RANGE_W    = 16;
    localparam int IDX_W      = 12;
    localparam int ANG_W      = 25;
    localparam int ACC_W      = 32;
    localparam int STEP_W     = 18;
    localparam int DW         = 38;
    localparam int ZW         = 27;
    localparam int HEAD_W     = 8;
    localparam int TAB_IDX_W  = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 72;

    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 8'd1;

    localparam logic signed [ANG_W-1:0] START_RST = -25'sd11796480;
    localparam logic [STEP_W-1:0]       STEP_RST  = 18'd32768;

    // sector bounds, 1/65536 degree
    localparam logic signed [ACC_W-1:0] ANG_M180 = -32'sd11796480;
    localparam logic signed [ACC_W-1:0] ANG_M90  = -32'sd5898240;
    localparam logic signed [ACC_W-1:0] ANG_P90  = 32'sd5898240;
    localparam logic signed [ACC_W-1:0] ANG_P180 = 32'sd11796480;

    localparam logic signed [ZW-1:0] Z_DEG180 = 27'sd11796480;
    localparam logic signed [ZW-1:0] Z_RND    = 27'sd65535;
    localparam logic signed [ZW-1:0] Z_H90    = 27'sd90;

    typedef struct packed {
        logic                     seen;
        logic [RANGE_W-1:0]       rng;
        logic signed [ANG_W-1:0]  angle;
        logic [IDX_W-1:0]         index;
    } best_t;

    localparam best_t BEST_RST = '{seen: 1'b0, rng: 16'hFFFF, angle: '0, index: '0};

    typedef struct packed {
        logic start;
        logic vec;
    } cdc_cmd_t;

    function automatic logic signed [ZW-1:0] atan_tab(input logic [TAB_IDX_W-1:0] i);
        logic signed [ZW-1:0] t;
        case (i)
            5'd0:    t = 27'sd2949120;
            5'd1:    t = 27'sd1740967;
            5'd2:    t = 27'sd919879;
            5'd3:    t = 27'sd466945;
            5'd4:    t = 27'sd234379;
            5'd5:    t = 27'sd117304;
            5'd6:    t = 27'sd58666;
            5'd7:    t = 27'sd29335;
            5'd8:    t = 27'sd14668;
            5'd9:    t = 27'sd7334;
            5'd10:   t = 27'sd3667;
            5'd11:   t = 27'sd1833;
            5'd12:   t = 27'sd917;
            5'd13:   t = 27'sd458;
            5'd14:   t = 27'sd229;
            5'd15:   t = 27'sd115;
            5'd16:   t = 27'sd57;
            5'd17:   t = 27'sd29;
            5'd18:   t = 27'sd14;
            5'd19:   t = 27'sd7;
            5'd20:   t = 27'sd4;
            5'd21:   t = 27'sd2;
            5'd22:   t = 27'sd1;
            default: t = 27'sd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

>>> rtl/lsca_tracker.sv
// Per-sample angle accumulation and nearest-sample tracking for both sectors.
`default_nettype none
module lsca_tracker #(
    parameter int MAX_SAMPLES = lsca_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sample_en,
    input  wire logic [lsca_pkg::RANGE_W-1:0]      range_mm,
    input  wire logic                              last,
    input  wire logic signed [lsca_pkg::ANG_W-1:0] start_angle,
    input  wire logic [lsca_pkg::STEP_W-1:0]       angle_step,
    output lsca_pkg::best_t                        left_upd,
    output lsca_pkg::best_t                        right_upd
);

    localparam int CNT_W = $clog2(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SAMPLES - 1);

    logic [lsca_pkg::ACC_W-1:0] acc_reg;
    logic [lsca_pkg::ACC_W-1:0] acc_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    lsca_pkg::best_t            left_reg;
    lsca_pkg::best_t            right_reg;

    logic [lsca_pkg::ACC_W-1:0]        au;
    logic signed [lsca_pkg::ACC_W-1:0] a;
    logic [CNT_W+lsca_pkg::IDX_W-1:0]  idx_ext;
    logic [lsca_pkg::IDX_W-1:0]        idx;
    logic                              left_hit;
    logic                              right_hit;

    assign au = (cnt_reg == '0)
              ? {{(lsca_pkg::ACC_W-lsca_pkg::ANG_W){start_angle[lsca_pkg::ANG_W-1]}}, start_angle}
              : acc_reg;
    assign a        = $signed(au);
    assign idx_ext  = {{lsca_pkg::IDX_W{1'b0}}, cnt_reg};
    assign idx      = idx_ext[lsca_pkg::IDX_W-1:0];
    assign acc_next = au + {{(lsca_pkg::ACC_W-lsca_pkg::STEP_W){1'b0}}, angle_step};
    assign cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;

    assign left_hit  = (a > lsca_pkg::ANG_M180) && (a <= lsca_pkg::ANG_M90)
                     && (range_mm <= left_reg.rng);
    assign right_hit = (a >= lsca_pkg::ANG_P90) && (a < lsca_pkg::ANG_P180)
                     && (range_mm <= right_reg.rng);

    always_comb
    begin
        left_upd  = left_reg;
        right_upd = right_reg;
        if (left_hit)
        begin
            left_upd = '{seen: 1'b1, rng: range_mm, angle: a[lsca_pkg::ANG_W-1:0], index: idx};
        end
        if (right_hit)
        begin
            right_upd = '{seen: 1'b1, rng: range_mm, angle: a[lsca_pkg::ANG_W-1:0], index: idx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            left_reg  <= lsca_pkg::BEST_RST;
            right_reg <= lsca_pkg::BEST_RST;
        end
        else if (sample_en)
        begin
            if (last)
            begin
                // scan closed: the next sample takes the start angle directly
                acc_reg   <= '0;
                cnt_reg   <= '0;
                left_reg  <= lsca_pkg::BEST_RST;
                right_reg <= lsca_pkg::BEST_RST;
            end
            else
            begin
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                left_reg  <= left_upd;
                right_reg <= right_upd;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/lsca_cordic.sv
// Shared CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
`default_nettype none
module lsca_cordic #(
    parameter int CORDIC_STEPS = lsca_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lsca_pkg::cdc_cmd_t             cmd,
    input  wire logic signed [lsca_pkg::DW-1:0] x_in,
    input  wire logic signed [lsca_pkg::DW-1:0] y_in,
    input  wire logic signed [lsca_pkg::ZW-1:0] z_in,
    output logic                                done,
    output logic signed [lsca_pkg::DW-1:0]      x_out,
    output logic signed [lsca_pkg::ZW-1:0]      z_out,
    output logic signed [lsca_pkg::DW-1:0]      y_out
);

    localparam int SW = $clog2(CORDIC_STEPS);
    localparam logic [SW-1:0] STEP_LAST = SW'(CORDIC_STEPS - 1);

    logic                          run_reg;
    logic                          done_reg;
    logic [SW-1:0]                 step_reg;
    logic                          vec_reg;
    logic signed [lsca_pkg::DW-1:0] x_reg;
    logic signed [lsca_pkg::DW-1:0] y_reg;
    logic signed [lsca_pkg::ZW-1:0] z_reg;

    logic signed [lsca_pkg::DW-1:0] xs;
    logic signed [lsca_pkg::DW-1:0] ys;
    logic signed [lsca_pkg::ZW-1:0] t;
    logic [SW+lsca_pkg::TAB_IDX_W-1:0] ti_ext;
    logic                          pos;

    assign ti_ext = {{lsca_pkg::TAB_IDX_W{1'b0}}, step_reg};
    assign t      = lsca_pkg::atan_tab(ti_ext[lsca_pkg::TAB_IDX_W-1:0]);
    assign xs     = x_reg >>> step_reg;
    assign ys     = y_reg >>> step_reg;
    assign pos    = vec_reg ? y_reg[lsca_pkg::DW-1] : !z_reg[lsca_pkg::ZW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (step_reg == STEP_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            vec_reg <= cmd.vec;
            x_reg   <= x_in;
            y_reg   <= y_in;
            z_reg   <= z_in;
        end
        else if (run_reg)
        begin
            if (pos)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - t;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + t;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !run_reg)
        else $error("CORDIC start while a run is in progress");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("CORDIC done held for more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("CORDIC done while still running");

endmodule
`default_nettype wire

>>> rtl/lidar_sector_centering_angle.sv
// Top level: lidar sector nearest-point tracking and heading error at scan end.
// A non-final sample is a one-cycle transfer; s_tready stays high while idle.
// A final sample starts the scan-end sequence: up to two CORDIC rotations and at most one
// vectoring pass on the shared unit, each started from its own control state (S_LEFT,
// S_RIGHT, S_VEC); a rotation is skipped for an empty sector, the pass when sy is zero.
// The result sits in an output register; sampling resumes once it is loaded there.
// Reset clears the scan state and sets start_angle and angle_step to their defaults.
`default_nettype none
module lidar_sector_centering_angle #(
    parameter int MAX_SAMPLES  = lsca_pkg::MAX_SAMPLES_DEF,
    parameter int CORDIC_STEPS = lsca_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lsca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lsca_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lsca_pkg::RANGE_W-1:0]     s_tdata,   // [15:0] range_mm
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] heading_error, [8] left_found, [9] right_found, [21:10] left_index,
    // [33:22] right_index, [49:34] left_range, [65:50] right_range, [71:66] zero
    output logic [lsca_pkg::OUT_DATA_W-1:0]       m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEFT,
        S_LEFT_RUN,
        S_RIGHT,
        S_RIGHT_RUN,
        S_VEC,
        S_VEC_RUN,
        S_OUT
    } state_t;

    state_t state_reg;

    logic signed [lsca_pkg::ANG_W-1:0] start_angle_reg;
    logic [lsca_pkg::STEP_W-1:0]       angle_step_reg;
    lsca_pkg::best_t                   job_left_reg;
    lsca_pkg::best_t                   job_right_reg;
    logic signed [lsca_pkg::DW-1:0]    sx_reg;
    logic signed [lsca_pkg::DW-1:0]    sy_reg;
    logic signed [lsca_pkg::HEAD_W-1:0] head_reg;
    logic                              m_tvalid_reg;
    logic [lsca_pkg::OUT_DATA_W-1:0]   m_tdata_reg;

    logic                              s_xfer;
    lsca_pkg::best_t                   left_upd;
    lsca_pkg::best_t                   right_upd;
    lsca_pkg::best_t                   rot_src;
    lsca_pkg::cdc_cmd_t                cdc_cmd;
    logic signed [lsca_pkg::DW-1:0]    cdc_x_in;
    logic signed [lsca_pkg::DW-1:0]    cdc_y_in;
    logic signed [lsca_pkg::ZW-1:0]    cdc_z_in;
    logic                              cdc_done;
    logic signed [lsca_pkg::DW-1:0]    cdc_x;
    logic signed [lsca_pkg::DW-1:0]    cdc_y;
    logic signed [lsca_pkg::ZW-1:0]    cdc_z;
    logic signed [lsca_pkg::ZW-1:0]    za;
    logic signed [lsca_pkg::ZW-1:0]    zq;
    logic signed [lsca_pkg::HEAD_W-1:0] head_vec;
    logic signed [lsca_pkg::HEAD_W-1:0] head_axis;
    logic                              out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg <= lsca_pkg::START_RST;
            angle_step_reg  <= lsca_pkg::STEP_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == lsca_pkg::REG_START_ANGLE)
            begin
                start_angle_reg <= cfg_data[lsca_pkg::ANG_W-1:0];
            end
            else if (cfg_index == lsca_pkg::REG_ANGLE_STEP)
            begin
                angle_step_reg <= cfg_data[lsca_pkg::STEP_W-1:0];
            end
        end
    end

    lsca_tracker #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_en   (s_xfer),
        .range_mm    (s_tdata),
        .last        (s_tlast),
        .start_angle (start_angle_reg),
        .angle_step  (angle_step_reg),
        .left_upd    (left_upd),
        .right_upd   (right_upd)
    );

    // rotation operand: sector angle moved by 180 degrees into [-90,90]
    assign rot_src = (state_reg == S_RIGHT) ? job_right_reg : job_left_reg;
    assign za      = {{(lsca_pkg::ZW-lsca_pkg::ANG_W){rot_src.angle[lsca_pkg::ANG_W-1]}},
                      rot_src.angle};

    always_comb
    begin
        cdc_cmd.vec   = (state_reg == S_VEC);
        cdc_cmd.start = ((state_reg == S_LEFT) && job_left_reg.seen)
                     || ((state_reg == S_RIGHT) && job_right_reg.seen)
                     || ((state_reg == S_VEC) && (sy_reg != '0));
        if (state_reg == S_VEC)
        begin
            cdc_z_in = '0;
            if (sy_reg > 0)
            begin
                cdc_x_in = sy_reg;
                cdc_y_in = -sx_reg;
            end
            else
            begin
                cdc_x_in = -sy_reg;
                cdc_y_in = sx_reg;
            end
        end
        else
        begin
            cdc_x_in = {{(lsca_pkg::DW-lsca_pkg::RANGE_W-16){1'b0}}, rot_src.rng, 16'h0000};
            cdc_y_in = '0;
            cdc_z_in = za[lsca_pkg::ZW-1] ? za + lsca_pkg::Z_DEG180 : za - lsca_pkg::Z_DEG180;
        end
    end

    lsca_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cdc_cmd),
        .x_in  (cdc_x_in),
        .y_in  (cdc_y_in),
        .z_in  (cdc_z_in),
        .done  (cdc_done),
        .x_out (cdc_x),
        .z_out (cdc_z),
        .y_out (cdc_y)
    );

    // whole degrees, truncated toward zero, clamped
    assign zq = cdc_z[lsca_pkg::ZW-1] ? ((cdc_z + lsca_pkg::Z_RND) >>> 16) : (cdc_z >>> 16);
    assign head_vec = (zq > lsca_pkg::Z_H90)  ? 8'sd90
                    : (zq < -lsca_pkg::Z_H90) ? -8'sd90
                    : zq[lsca_pkg::HEAD_W-1:0];
    assign head_axis = (sx_reg > 0) ? 8'sd90 : ((sx_reg < 0) ? -8'sd90 : 8'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_left_reg  <= lsca_pkg::BEST_RST;
            job_right_reg <= lsca_pkg::BEST_RST;
            sx_reg        <= '0;
            sy_reg        <= '0;
            head_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_xfer && s_tlast)
                    begin
                        job_left_reg  <= left_upd;
                        job_right_reg <= right_upd;
                        sx_reg        <= '0;
                        sy_reg        <= '0;
                        state_reg     <= S_LEFT;
                    end
                end
                S_LEFT:
                begin
                    state_reg <= job_left_reg.seen ? S_LEFT_RUN : S_RIGHT;
                end
                S_LEFT_RUN:
                begin
                    if (cdc_done)
                    begin
                        sx_reg    <= sx_reg - cdc_y;
                        sy_reg    <= sy_reg - cdc_x;
                        state_reg <= S_RIGHT;
                    end
                end
                S_RIGHT:
                begin
                    state_reg <= job_right_reg.seen ? S_RIGHT_RUN : S_VEC;
                end
                S_RIGHT_RUN:
                begin
                    if (cdc_done)
                    begin
                        sx_reg    <= sx_reg - cdc_y;
                        sy_reg    <= sy_reg - cdc_x;
                        state_reg <= S_VEC;
                    end
                end
                S_VEC:
                begin
                    if (sy_reg == '0)
                    begin
                        head_reg  <= head_axis;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_VEC_RUN;
                    end
                end
                S_VEC_RUN:
                begin
                    if (cdc_done)
                    begin
                        head_reg  <= head_vec;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0,
                                         job_right_reg.rng,
                                         job_left_reg.rng,
                                         job_right_reg.index,
                                         job_left_reg.index,
                                         job_right_reg.seen,
                                         job_left_reg.seen,
                                         head_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        cdc_done |-> (state_reg == S_LEFT_RUN || state_reg == S_RIGHT_RUN
                      || state_reg == S_VEC_RUN))
        else $error("CORDIC done outside a waiting state");

    a_last_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == S_LEFT))
        else $error("final sample did not start the scan-end sequence");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[7:0]) >= -8'sd90 && $signed(m_tdata[7:0]) <= 8'sd90))
        else $error("heading error outside +/-90");

    a_empty_left: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[49:34] == 16'hFFFF && m_tdata[21:10] == 12'd0))
        else $error("empty left sector with non-default fields");

endmodule
`default_nettype wire
